>>> sv/ctw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctw_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_FIRST = 2'd2;
  localparam logic [1:0] OP_NEXT = 2'd3;
  localparam logic [7:0] T_NULL = 8'h00;
  localparam logic [7:0] T_INDIRECT = 8'h03;
  localparam logic [7:0] T_LONGLINK_MFC = 8'h06;
  localparam logic [7:0] T_LONGLINK_A = 8'h11;
  localparam logic [7:0] T_LONGLINK_C = 8'h12;
  localparam logic [7:0] T_LINKTARGET = 8'h13;
  localparam logic [7:0] T_NO_LINK = 8'h14;
  localparam logic [7:0] T_END = 8'hff;
  localparam logic [7:0] MFC_ATTR_CODE = 8'h00;
  localparam logic [3:0] SP_ATTR = 4'd1;
  localparam logic [3:0] SP_INDIRECT = 4'd8;
  localparam int unsigned WALK_LIMIT = 512;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] desired_code;
    logic any_tuple;
    logic return_links;
    logic return_common;
    logic function_all;
    logic [7:0] function_number;
  } in_item_t;

  typedef struct packed {
    logic status;
    logic [7:0] tuple_code;
    logic [7:0] tuple_link;
    logic [31:0] data_offset;
    logic in_attribute_space;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PRO_INIT, S_WALK_INIT, S_STEP, S_RD, S_RDW, S_LINKHDR, S_CLASSIFY,
    S_FOLLOW, S_FOLLOW_MFC, S_TGT, S_TGT_CHK, S_LL_RD, S_MFC_CNT, S_ADVANCE,
    S_WALK_DONE, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    R_HDR, R_FOLLOW, R_MFC, R_TGT, R_LL, R_CNT
  } rd_ret_e;
endpackage
`default_nettype wire

>>> sv/ctw_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ctw_in_if;
  import ctw_pkg::*;
  logic valid;
  logic ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ctw_out_if;
  import ctw_pkg::*;
  logic valid;
  logic ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ctw_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/ctw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ctw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/ctw_fetch.sv
`timescale 1ns / 1ps
`default_nettype none
// reads a block of len bytes at addr, one byte a cycle, all 0xff when out of range
module ctw_fetch #(
  parameter int unsigned CIS_BYTES = 512
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [31:0]                  addr_i,
  input  wire logic [2:0]                   len_i,
  input  wire logic [$clog2(CIS_BYTES):0]   loaded_i,
  output logic      [$clog2(CIS_BYTES)-1:0] raddr_o,
  input  wire logic [7:0]                   rdata_i,
  output logic                              busy_o,
  output logic      [39:0]                  buf_o
);
  localparam int unsigned AW = $clog2(CIS_BYTES);
  logic [31:0] base_q, base_d;
  logic [2:0] len_q, len_d, cnt_q, cnt_d;
  logic ok_q, ok_d, busy_q, busy_d, pend_q, pend_d;
  logic [2:0] wr_q, wr_d;
  logic [39:0] buf_q, buf_d;
  logic [32:0] lim;

  assign lim = {1'b0, addr_i} + {30'd0, len_i};
  assign raddr_o = base_q[AW-1:0] + AW'(cnt_q);
  assign busy_o = busy_q | start_i;
  assign buf_o = buf_q;

  always_comb begin
    base_d = base_q; len_d = len_q; cnt_d = cnt_q; ok_d = ok_q;
    busy_d = busy_q; pend_d = 1'b0; wr_d = cnt_q; buf_d = buf_q;
    if (pend_q) buf_d[wr_q*8 +: 8] = ok_q ? rdata_i : 8'hff;
    if (start_i) begin
      base_d = addr_i; len_d = len_i; cnt_d = '0; busy_d = 1'b1;
      ok_d = (lim <= 33'(loaded_i)) && (lim <= 33'(CIS_BYTES));
    end else if (busy_q) begin
      if (cnt_q == len_q) begin
        busy_d = pend_q;
      end else begin
        pend_d = 1'b1; cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      busy_q <= busy_d; pend_q <= pend_d;
    end
  end
  always_ff @(posedge clk_i) begin
    base_q <= base_d; len_q <= len_d; cnt_q <= cnt_d; ok_q <= ok_d;
    wr_q <= wr_d; buf_q <= buf_d;
  end
endmodule
`default_nettype wire

>>> sv/cis_tuple_chain_walker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// cis tuple chain walker
// in_if carries one command per transfer: clear, append a byte, find first, find next.
// cfg_if is always ready; the user must write function_count over it only while the
// block is idle, which the block does not enforce. out_if returns one result per
// command, held in an output register until taken. clear and append present their
// result the cycle after the transfer; a search walks the chain through one
// byte-serial fetch unit on a single ram read port; a first search may run up to
// three walks, each bounded at 512 tuples.
// in_if.ready is low from acceptance until the result has been transferred out;
// a stalled receiver just holds the block, nothing is dropped.
// reset empties the image and clears the walk state, function_count goes to 1.
// image ram contents are not cleared; bytes at or above the loaded count read as 0xff.
module cis_tuple_chain_walker_unit #(
  parameter int unsigned CIS_BYTES = 512
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ctw_in_if.sink   in_if,
  ctw_out_if.source out_if,
  ctw_cfg_if.sink  cfg_if
);
  import ctw_pkg::*;
  localparam int unsigned AW = $clog2(CIS_BYTES);

  state_e st_q, st_d;
  rd_ret_e ret_q, ret_d;
  in_item_t cmd_q, cmd_d;
  out_item_t res_q, res_d;
  logic [7:0] fcnt_q;
  logic [AW:0] loaded_q, loaded_d;
  logic [31:0] cis_ofs_q, cis_ofs_d, link_ofs_q, link_ofs_d, ofs_q, ofs_d, tgt_q, tgt_d;
  logic [7:0] tlink_q, tlink_d, c0_q, c0_d, c1_q, c1_d, want_q, want_d, mfc_q, mfc_d;
  logic has_link_q, has_link_d, first_q, first_d, second_q, second_d;
  logic [3:0] lspace_q, lspace_d, space_q, space_d, attr_q, attr_d;
  logic [9:0] iter_q, iter_d;
  logic [1:0] phase_q, phase_d;
  logic f_start;
  logic [31:0] f_addr;
  logic [2:0] f_len;
  logic f_busy;
  logic [39:0] f_buf;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic we;
  logic is_tgt;

  assign we = in_if.valid && in_if.ready && in_if.payload.op == OP_APPEND &&
              loaded_q < (AW+1)'(CIS_BYTES);

  ctw_ram #(.WIDTH(8), .DEPTH(CIS_BYTES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(loaded_q[AW-1:0]), .wdata_i(in_if.payload.data_byte),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  ctw_fetch #(.CIS_BYTES(CIS_BYTES)) u_fetch (
    .clk_i, .rst_ni, .start_i(f_start), .addr_i(f_addr), .len_i(f_len),
    .loaded_i(loaded_q), .raddr_o(raddr), .rdata_i(rdata), .busy_o(f_busy), .buf_o(f_buf)
  );

  assign in_if.ready = (st_q == S_IDLE);
  assign out_if.valid = (st_q == S_OUT);
  assign out_if.payload = res_q;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fcnt_q <= 8'd1;
    else if (cfg_if.valid) fcnt_q <= cfg_if.data;
  end

  assign is_tgt = f_buf[7:0] == T_LINKTARGET && f_buf[15:8] >= 8'd3 &&
                  f_buf[23:16] == 8'h43 && f_buf[31:24] == 8'h49 && f_buf[39:32] == 8'h53;

  always_comb begin
    st_d = st_q; ret_d = ret_q; cmd_d = cmd_q; res_d = res_q; loaded_d = loaded_q;
    cis_ofs_d = cis_ofs_q; link_ofs_d = link_ofs_q; ofs_d = ofs_q; tgt_d = tgt_q;
    tlink_d = tlink_q; c0_d = c0_q; c1_d = c1_q; want_d = want_q; mfc_d = mfc_q;
    has_link_d = has_link_q; first_d = first_q; second_d = second_q;
    lspace_d = lspace_q; space_d = space_q; attr_d = attr_q; iter_d = iter_q;
    phase_d = phase_q; f_start = 1'b0; f_addr = ofs_q; f_len = 3'd2;
    case (st_q)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_d = in_if.payload;
          res_d = '0;
          case (in_if.payload.op)
            OP_CLEAR: begin loaded_d = '0; st_d = S_OUT; end
            OP_APPEND: begin
              if (loaded_q < (AW+1)'(CIS_BYTES)) loaded_d = loaded_q + 1'b1;
              else res_d.status = 1'b1;
              st_d = S_OUT;
            end
            OP_FIRST: begin
              tlink_d = '0; lspace_d = '0; mfc_d = '0; cis_ofs_d = '0; link_ofs_d = '0;
              space_d = SP_ATTR; has_link_d = 1'b1;
              if (fcnt_q > 8'd1 && !in_if.payload.return_common) begin
                phase_d = 2'd0; st_d = S_PRO_INIT;
              end else begin
                phase_d = 2'd2; st_d = S_WALK_INIT;
              end
            end
            default: begin phase_d = 2'd2; st_d = S_WALK_INIT; end
          endcase
        end
      end
      S_PRO_INIT: st_d = S_WALK_INIT;
      S_WALK_INIT: begin
        c0_d = '0; c1_d = tlink_q; ofs_d = cis_ofs_q + {24'd0, tlink_q};
        attr_d = space_q; iter_d = '0;
        case (phase_q)
          2'd0: begin want_d = T_LONGLINK_MFC; first_d = 1'b0; end
          2'd1: begin want_d = T_LINKTARGET; first_d = 1'b0; end
          default: begin
            want_d = cmd_q.any_tuple ? T_END : cmd_q.desired_code;
            first_d = cmd_q.any_tuple;
          end
        endcase
        st_d = S_STEP;
      end
      S_STEP: begin
        if (iter_q == 10'(WALK_LIMIT)) begin
          st_d = S_WALK_DONE; res_d.status = 1'b1;
        end else if (c1_q == 8'hff) begin
          c0_d = T_END; st_d = S_FOLLOW;
        end else begin
          f_start = 1'b1; f_addr = ofs_q; f_len = 3'd2; ret_d = R_HDR; st_d = S_RDW;
        end
      end
      S_RDW: if (!f_busy) st_d = S_RD;
      S_RD: begin
        case (ret_q)
          R_HDR: begin
            c0_d = f_buf[7:0]; c1_d = f_buf[15:8];
            if (f_buf[7:0] == T_NULL) begin
              ofs_d = ofs_q + 32'd1; iter_d = iter_q + 10'd1; st_d = S_STEP;
            end else if (f_buf[7:0] == T_END) st_d = S_FOLLOW;
            else st_d = S_CLASSIFY;
          end
          R_FOLLOW: begin
            c0_d = f_buf[7:0]; c1_d = f_buf[15:8]; st_d = S_CLASSIFY;
          end
          R_MFC: begin
            tgt_d = f_buf[39:8];
            space_d = (f_buf[7:0] == MFC_ATTR_CODE) ? 4'd1 : 4'd0;
            link_ofs_d = link_ofs_q + 32'd5; mfc_d = mfc_q - 8'd1;
            second_d = (f_buf[7:0] == MFC_ATTR_CODE); st_d = S_TGT;
          end
          R_TGT: st_d = S_TGT_CHK;
          R_LL: begin link_ofs_d = f_buf[31:0]; st_d = S_ADVANCE; end
          default: begin mfc_d = f_buf[7:0]; st_d = S_ADVANCE; end
        endcase
      end
      S_FOLLOW: begin
        if (mfc_q != 8'd0) begin
          f_start = 1'b1; f_addr = link_ofs_q; f_len = 3'd5; ret_d = R_MFC; st_d = S_RDW;
        end else if (has_link_q) begin
          tgt_d = link_ofs_q; space_d = lspace_q; has_link_d = 1'b0;
          second_d = (lspace_q != 4'd0); st_d = S_TGT;
        end else begin
          res_d.status = 1'b1; st_d = S_WALK_DONE;
        end
      end
      S_TGT: begin
        f_start = 1'b1; f_addr = tgt_q; f_len = 3'd5; ret_d = R_TGT; st_d = S_RDW;
      end
      S_TGT_CHK: begin
        if (is_tgt) begin
          ofs_d = tgt_q; attr_d = space_q;
          f_start = 1'b1; f_addr = tgt_q; f_len = 3'd2; ret_d = R_FOLLOW; st_d = S_RDW;
        end else if (second_q) begin
          second_d = 1'b0; tgt_d = {1'b0, tgt_q[31:1]}; st_d = S_TGT;
        end else begin
          res_d.status = 1'b1; st_d = S_WALK_DONE;
        end
      end
      S_CLASSIFY: begin
        st_d = S_LINKHDR;
        if (c0_q == T_LONGLINK_A || c0_q == T_LONGLINK_C || c0_q == T_LONGLINK_MFC ||
            c0_q == T_LINKTARGET || c0_q == T_INDIRECT || c0_q == T_NO_LINK) begin
          if (c0_q == T_LONGLINK_A || c0_q == T_LONGLINK_C) begin
            has_link_d = 1'b1;
            lspace_d = (c0_q == T_LONGLINK_A) ? (attr_q | SP_ATTR) : (attr_q & ~SP_ATTR);
            f_start = 1'b1; f_addr = ofs_q + 32'd2; f_len = 3'd4; ret_d = R_LL; st_d = S_RDW;
          end else if (c0_q == T_INDIRECT) begin
            has_link_d = 1'b1; lspace_d = SP_ATTR | SP_INDIRECT; link_ofs_d = '0;
          end else if (c0_q == T_LONGLINK_MFC) begin
            lspace_d = attr_q;
            if (cmd_q.function_all) begin
              link_ofs_d = ofs_q + 32'd3;
              f_start = 1'b1; f_addr = ofs_q + 32'd2; f_len = 3'd1; ret_d = R_CNT;
              st_d = S_RDW;
            end else begin
              mfc_d = 8'd1;
              link_ofs_d = ofs_q + 32'd3 + {22'd0, cmd_q.function_number, 2'b00}
                           + {24'd0, cmd_q.function_number};
            end
          end else if (c0_q == T_NO_LINK) has_link_d = 1'b0;
          if (st_d == S_LINKHDR) st_d = S_ADVANCE;
        end else st_d = S_ADVANCE;
      end
      S_ADVANCE: begin
        if (first_q && (cmd_q.return_links || !(c0_q == T_LONGLINK_A ||
            c0_q == T_LONGLINK_C || c0_q == T_LONGLINK_MFC || c0_q == T_LINKTARGET ||
            c0_q == T_INDIRECT || c0_q == T_NO_LINK)) || c0_q == want_q) begin
          tlink_d = c1_q; cis_ofs_d = ofs_q + 32'd2; st_d = S_WALK_DONE;
        end else begin
          ofs_d = ofs_q + {24'd0, c1_q} + 32'd2; iter_d = iter_q + 10'd1; st_d = S_STEP;
        end
      end
      S_WALK_DONE: begin
        case (phase_q)
          2'd0: begin
            if (res_q.status) begin
              res_d.status = 1'b0; cis_ofs_d = '0; tlink_d = '0; phase_d = 2'd2;
            end else phase_d = 2'd1;
            st_d = S_WALK_INIT;
          end
          2'd1: begin
            if (res_q.status) st_d = S_OUT;
            else begin phase_d = 2'd2; st_d = S_WALK_INIT; end
          end
          default: begin
            if (!res_q.status) begin
              res_d.tuple_code = c0_q; res_d.tuple_link = c1_q;
              res_d.data_offset = ofs_q + 32'd2; res_d.in_attribute_space = space_q[0];
            end
            st_d = S_OUT;
          end
        endcase
      end
      S_OUT: if (out_if.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; loaded_q <= '0; cis_ofs_q <= '0; tlink_q <= '0; link_ofs_q <= '0;
      has_link_q <= 1'b0; lspace_q <= '0; space_q <= '0; mfc_q <= '0;
    end else begin
      st_q <= st_d; loaded_q <= loaded_d; cis_ofs_q <= cis_ofs_d; tlink_q <= tlink_d;
      link_ofs_q <= link_ofs_d; has_link_q <= has_link_d; lspace_q <= lspace_d;
      space_q <= space_d; mfc_q <= mfc_d;
    end
  end
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; cmd_q <= cmd_d; res_q <= res_d; ofs_q <= ofs_d; tgt_q <= tgt_d;
    c0_q <= c0_d; c1_q <= c1_d; want_q <= want_d; first_q <= first_d;
    second_q <= second_d; attr_q <= attr_d; iter_q <= iter_d;
    phase_q <= phase_d;
  end

`ifndef NO_ASSERTIONS
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= (AW+1)'(CIS_BYTES)) else $error("loaded count overflow");
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && res_q.status |-> res_q.data_offset == 32'd0 && res_q.tuple_code == 8'd0)
    else $error("failed result carries data");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(res_q))
    else $error("result changed under stall");
`endif
endmodule
`default_nettype wire

>>> bench/cis_tuple_chain_walker_unit_tb.sv
`timescale 1ns / 1ps
module cis_tuple_chain_walker_unit_tb;
  import ctw_pkg::*;

  localparam int unsigned IMG_BYTES = 512;

  class cis_walk_scoreboard;
    logic [7:0]  img [IMG_BYTES];
    int unsigned loaded;
    logic [31:0] cur_ofs;
    logic [7:0]  cur_link;
    logic [31:0] lnk_ofs;
    logic        lnk_pending;
    logic [3:0]  lnk_space;
    logic [3:0]  cur_space;
    logic [7:0]  mfc_left;
    logic [7:0]  fn_count;
    out_item_t   pending_q[$];
    int          mismatches;

    function void reset_state();
      loaded = 0; cur_ofs = 0; cur_link = 0; lnk_ofs = 0; lnk_pending = 0;
      lnk_space = 0; cur_space = 0; mfc_left = 0; fn_count = 1;
      mismatches = 0;
      pending_q.delete();
    endfunction

    function logic [7:0] rd_byte(logic [31:0] addr, logic [31:0] len, int k);
      logic [32:0] lim;
      lim = {1'b0, addr} + {1'b0, len};
      if (lim <= loaded && lim <= IMG_BYTES) return img[addr + k];
      return 8'hff;
    endfunction

    function bit is_target(logic [31:0] ofs);
      return rd_byte(ofs, 5, 0) == T_LINKTARGET && rd_byte(ofs, 5, 1) >= 3 &&
             rd_byte(ofs, 5, 2) == "C" && rd_byte(ofs, 5, 3) == "I" &&
             rd_byte(ofs, 5, 4) == "S";
    endfunction

    function bit take_link(output logic [31:0] res);
      logic [31:0] ofs;
      res = 0;
      if (mfc_left != 0) begin
        ofs = {rd_byte(lnk_ofs, 5, 4), rd_byte(lnk_ofs, 5, 3),
               rd_byte(lnk_ofs, 5, 2), rd_byte(lnk_ofs, 5, 1)};
        cur_space = (rd_byte(lnk_ofs, 5, 0) == MFC_ATTR_CODE) ? 4'd1 : 4'd0;
        lnk_ofs = lnk_ofs + 32'd5;
        mfc_left = mfc_left - 8'd1;
      end else if (lnk_pending) begin
        ofs = lnk_ofs;
        cur_space = lnk_space;
        lnk_pending = 0;
      end else begin
        return 0;
      end
      if (cur_space != 0) begin
        if (is_target(ofs)) begin
          res = ofs;
          return 1;
        end
        ofs = ofs >> 1;
      end
      if (is_target(ofs)) begin
        res = ofs;
        return 1;
      end
      return 0;
    endfunction

    function bit walk_chain(bit first, logic [7:0] want, bit ret_links, bit fn_all,
                            logic [7:0] fn_num, output logic [7:0] code);
      logic [7:0]  c0, c1;
      logic [31:0] ofs;
      logic [3:0]  attr;
      int          i;
      bit          stop;
      c0 = 0; c1 = cur_link; ofs = cur_ofs + {24'd0, cur_link}; attr = cur_space;
      stop = 0; code = 0;
      for (i = 0; i < WALK_LIMIT && !stop; i++) begin
        if (c1 == 8'hff) begin
          c0 = T_END;
        end else begin
          c0 = rd_byte(ofs, 2, 0); c1 = rd_byte(ofs, 2, 1);
          if (c0 == T_NULL) begin
            ofs = ofs + 32'd1;
            continue;
          end
        end
        if (c0 == T_END) begin
          if (!take_link(ofs)) return 0;
          attr = cur_space;
          c0 = rd_byte(ofs, 2, 0); c1 = rd_byte(ofs, 2, 1);
        end
        if (c0 inside {T_LONGLINK_A, T_LONGLINK_C, T_LONGLINK_MFC, T_LINKTARGET,
                       T_INDIRECT, T_NO_LINK}) begin
          if (c0 == T_LONGLINK_A || c0 == T_LONGLINK_C) begin
            lnk_pending = 1;
            lnk_space = (c0 == T_LONGLINK_A) ? (attr | SP_ATTR) : (attr & ~SP_ATTR);
            lnk_ofs = {rd_byte(ofs + 2, 4, 3), rd_byte(ofs + 2, 4, 2),
                       rd_byte(ofs + 2, 4, 1), rd_byte(ofs + 2, 4, 0)};
          end else if (c0 == T_INDIRECT) begin
            lnk_pending = 1;
            lnk_space = SP_ATTR | SP_INDIRECT;
            lnk_ofs = 0;
          end else if (c0 == T_LONGLINK_MFC) begin
            lnk_ofs = ofs + 32'd3;
            lnk_space = attr;
            if (fn_all) begin
              mfc_left = rd_byte(ofs + 2, 1, 0);
            end else begin
              mfc_left = 1;
              lnk_ofs = lnk_ofs + {24'd0, fn_num} * 32'd5;
            end
          end else if (c0 == T_NO_LINK) begin
            lnk_pending = 0;
          end
          if (ret_links && first) stop = 1;
        end else if (first) begin
          stop = 1;
        end
        if (!stop && c0 == want) stop = 1;
        if (!stop) ofs = ofs + {24'd0, c1} + 32'd2;
      end
      if (!stop) return 0;
      code = c0;
      cur_link = c1;
      cur_ofs = ofs + 32'd2;
      return 1;
    endfunction

    function void note_command(in_item_t it);
      out_item_t   r;
      logic [7:0]  want, code, scratch;
      bit          ok;
      r = '0; ok = 1; code = 0;
      if (it.op == OP_CLEAR) begin
        loaded = 0;
      end else if (it.op == OP_APPEND) begin
        if (loaded < IMG_BYTES) begin
          img[loaded] = it.data_byte;
          loaded++;
        end else begin
          r.status = 1;
        end
      end else begin
        want = it.any_tuple ? 8'hff : it.desired_code;
        if (it.op == OP_FIRST) begin
          cur_link = 0; lnk_space = 0; mfc_left = 0; cur_ofs = 0; lnk_ofs = 0;
          cur_space = 1; lnk_pending = 1;
          if (fn_count > 1 && !it.return_common) begin
            if (walk_chain(0, T_LONGLINK_MFC, it.return_links, it.function_all,
                           it.function_number, scratch)) begin
              if (!walk_chain(0, T_LINKTARGET, it.return_links, it.function_all,
                              it.function_number, scratch))
                ok = 0;
            end else begin
              cur_ofs = 0;
              cur_link = 0;
            end
          end
        end
        if (ok)
          ok = walk_chain(it.any_tuple, want, it.return_links, it.function_all,
                          it.function_number, code);
        if (!ok) begin
          r.status = 1;
        end else begin
          r.tuple_code = code;
          r.tuple_link = cur_link;
          r.data_offset = cur_ofs;
          r.in_attribute_space = cur_space[0];
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status || got.tuple_code !== exp.tuple_code ||
          got.tuple_link !== exp.tuple_link || got.data_offset !== exp.data_offset ||
          got.in_attribute_space !== exp.in_attribute_space) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d code=%h link=%h ofs=%h attr=%0d, %s",
                   exp.status, exp.tuple_code, exp.tuple_link, exp.data_offset,
                   exp.in_attribute_space,
                   $sformatf("got st=%0d code=%h link=%h ofs=%h attr=%0d",
                             got.status, got.tuple_code, got.tuple_link,
                             got.data_offset, got.in_attribute_space));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  cis_walk_scoreboard sb;

  ctw_in_if  in_if ();
  ctw_out_if out_if ();
  ctw_cfg_if cfg_if ();

  cis_tuple_chain_walker_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #500ms;
    $display("** cis_tuple_chain_walker_unit: FAILED **");
    $finish;
  end

  // result side: random wait per result, check at each transfer
  initial begin
    int wait_cycles;
    out_if.ready = 0;
    wait (rst_ni);
    forever begin
      wait_cycles = $urandom_range(0, 3);
      @(negedge clk_i);
      out_if.ready = 0;
      repeat (wait_cycles) @(negedge clk_i);
      out_if.ready = 1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.payload);
    end
  end

  task automatic send_cmd(in_item_t it);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk_i);
    in_if.payload = it;
    in_if.valid = 1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(it);
    @(negedge clk_i);
    in_if.valid = 0;
  endtask

  task automatic write_fn_count(logic [7:0] v);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_if.data = v;
    cfg_if.valid = 1;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.fn_count = v;
    @(negedge clk_i);
    cfg_if.valid = 0;
  endtask

  function automatic in_item_t mk(logic [1:0] op, logic [7:0] d);
    in_item_t it;
    it = in_item_t'($urandom);
    it.data_byte = 8'($urandom);
    it.desired_code = 8'($urandom);
    it.function_number = 8'($urandom);
    it.op = op;
    if (op == OP_APPEND) it.data_byte = d;
    return it;
  endfunction

  task automatic add(logic [7:0] b);
    send_cmd(mk(OP_APPEND, b));
  endtask

  task automatic add_target();
    add(T_LINKTARGET); add(8'd3); add("C"); add("I"); add("S");
  endtask

  // builds a random but mostly well-formed chain
  task automatic build_chain();
    int n, k, len, lim;
    logic [7:0] c;
    send_cmd(mk(OP_CLEAR, 8'd0));
    lim = $urandom_range(20, 80);
    if ($urandom_range(0, 2) != 0) add_target();
    n = 0;
    while (n < lim) begin
      k = $urandom_range(0, 15);
      case (k)
        0: begin add(T_NULL); n++; end
        1: begin
          add(8'(T_LONGLINK_A + $urandom_range(0, 1))); add(8'd4);
          add(8'($urandom_range(0, lim))); add(8'd0); add(8'd0); add(8'd0); n += 6;
        end
        2: begin
          add(T_LONGLINK_MFC); add(8'd11); add(8'($urandom_range(0, 2)));
          repeat (2) begin
            add(8'($urandom_range(0, 1))); add(8'($urandom_range(0, lim)));
            add(8'd0); add(8'd0); add(8'd0);
          end
          n += 13;
        end
        3: begin add_target(); n += 5; end
        4: begin add(T_INDIRECT); add(8'd0); n += 2; end
        5: begin add(T_NO_LINK); add(8'd0); n += 2; end
        6: begin add(T_END); n++; end
        7: begin add(8'($urandom)); n++; end
        default: begin
          c = 8'($urandom_range(0, 31));
          len = $urandom_range(0, 4);
          if ($urandom_range(0, 20) == 0) len = 255;
          add(c); add(8'(len)); n += 2;
          if (len != 255) begin
            repeat (len) add(8'($urandom));
            n += len;
          end
        end
      endcase
    end
    if ($urandom_range(0, 1)) add(T_END);
  endtask

  task automatic search(logic [1:0] op);
    in_item_t it;
    it = mk(op, 8'd0);
    if ($urandom_range(0, 1)) it.desired_code = 8'($urandom_range(0, 31));
    if ($urandom_range(0, 1)) it.function_number = 8'($urandom_range(0, 2));
    send_cmd(it);
  endtask

  initial begin
    int i;
    sb = new();
    sb.reset_state();
    rst_ni = 0;
    in_if.valid = 0;
    in_if.payload = '0;
    cfg_if.valid = 0;
    cfg_if.data = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;

    // directed: empty image, full image, tuples with link byte 0xff
    search(OP_FIRST);
    search(OP_NEXT);
    add(8'h20); add(8'hff);
    send_cmd(mk(OP_FIRST, 8'd0));
    search(OP_NEXT);
    for (i = 0; i < IMG_BYTES; i++) add(i[0] ? 8'h00 : 8'hff);
    add(8'h55);
    add(8'haa);
    search(OP_FIRST);
    search(OP_NEXT);
    write_fn_count(8'd0);
    search(OP_FIRST);
    write_fn_count(8'd255);
    build_chain();
    repeat (4) search(OP_FIRST);

    for (i = 0; i < 8; i++) begin
      if (i % 4 == 1) write_fn_count(8'($urandom));
      if (i % 4 == 3) write_fn_count(8'($urandom_range(0, 2)));
      build_chain();
      repeat ($urandom_range(4, 12)) search($urandom_range(0, 1) ? OP_FIRST : OP_NEXT);
    end
    write_fn_count(8'd1);
    build_chain();
    repeat (10) search(OP_NEXT);

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("** cis_tuple_chain_walker_unit: PASSED **");
    else
      $display("** cis_tuple_chain_walker_unit: FAILED **");
    $finish;
  end
endmodule

>>> files.f
sv/ctw_pkg.sv
sv/ctw_if.sv
sv/ctw_ram.sv
sv/ctw_fetch.sv
sv/cis_tuple_chain_walker_unit.sv
bench/cis_tuple_chain_walker_unit_tb.sv
